// ===== hdl/glse_pkg.sv =====
// Shared types and constants for the grid line square enumerator.
// Used by glse_walker and grid_line_square_enumerator_core; no dependencies.
package glse_pkg;

   localparam int COORD_BITS = 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // One move from a start square to an end square.
   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   // One touched square of a move.
   typedef struct packed {
      coord_type square_x;
      coord_type square_y;
      logic      last_square;
      logic      too_far;
   } rsp_type;

   // Walk set-up handed from the request decode to the walker.
   typedef struct packed {
      logic                  go;
      coord_type             sx;
      coord_type             sy;
      logic [COORD_BITS:0]   ax;
      logic [COORD_BITS:0]   ay;
      logic                  gx;
      logic                  gy;
   } walk_load_type;

   // Square produced by the walker in the current cycle.
   typedef struct packed {
      logic      valid;
      coord_type x;
      coord_type y;
      logic      last;
   } walk_sq_type;

endpackage

// ===== hdl/grid_line_square_enumerator_core.sv =====
// Top level of the grid line square enumerator: request decode, walker and
// registered result port. Depends on glse_pkg and glse_walker.
//
//   channel   ports                      direction  handshake
//   request   start, busy, req           in         taken when start & !busy
//   result    rsp_strobe, rsp            out        one square per strobe, no stall
//
// A move touching n squares keeps busy high while they are walked, one square per
// cycle from the walker's single add-and-compare unit; n is at most 3*MAX_DELTA+1.
// Each square appears on rsp in the cycle after the walker produces it.
// A move that is too long yields its one result without raising busy.
// Reset returns the block to idle; there are no stalls on the result side.
module grid_line_square_enumerator_core import glse_pkg::*; #(
   parameter int MAX_DELTA = 15
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic [COORD_BITS:0]        ax;
   logic [COORD_BITS:0]        ay;
   logic                       too_far;
   logic                       accept;
   logic                       walk_busy;
   walk_load_type              load;
   walk_sq_type                square;

   logic                       rsp_strobe_ff, rsp_strobe_in;
   rsp_type                    rsp_ff, rsp_in;

   assign dx = $signed({req.end_x[COORD_BITS-1], req.end_x})
             - $signed({req.start_x[COORD_BITS-1], req.start_x});
   assign dy = $signed({req.end_y[COORD_BITS-1], req.end_y})
             - $signed({req.start_y[COORD_BITS-1], req.start_y});
   assign ax = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
   assign ay = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
   assign too_far = (ax > (COORD_BITS+1)'(MAX_DELTA)) || (ay > (COORD_BITS+1)'(MAX_DELTA));

   assign busy   = walk_busy;
   assign accept = start && !walk_busy;

   assign load.go = accept && !too_far;
   assign load.sx = req.start_x;
   assign load.sy = req.start_y;
   assign load.ax = ax;
   assign load.ay = ay;
   assign load.gx = !dx[COORD_BITS] && (dx != '0);
   assign load.gy = !dy[COORD_BITS] && (dy != '0);

   glse_walker #(
      .MAX_DELTA(MAX_DELTA)
   ) u_walker (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .busy   (walk_busy),
      .square (square)
   );

   always_comb begin
      if (accept && too_far) begin
         rsp_strobe_in      = 1'b1;
         rsp_in.square_x    = req.start_x;
         rsp_in.square_y    = req.start_y;
         rsp_in.last_square = 1'b1;
         rsp_in.too_far     = 1'b1;
      end else begin
         rsp_strobe_in      = square.valid;
         rsp_in.square_x    = square.x;
         rsp_in.square_y    = square.y;
         rsp_in.last_square = square.last;
         rsp_in.too_far     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ===== hdl/glse_walker.sv =====
// Sequencer that walks the touched squares of one move, one square a cycle,
// with a single add-and-compare unit on the doubled-x line test. Uses glse_pkg.
module glse_walker import glse_pkg::*; #(
   parameter int MAX_DELTA = 15
) (
   input  logic          clock,
   input  logic          reset,
   input  walk_load_type load,
   output logic          busy,
   output walk_sq_type   square
);

   localparam int DW = $clog2(MAX_DELTA + 1);
   localparam int AW = $clog2(MAX_DELTA * (2 * MAX_DELTA + 3) + 1) + 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic                  state_ff, state_in;
   logic [DW-1:0]         col_ff, col_in;
   logic [DW-1:0]         row_ff, row_in;
   logic [DW-1:0]         ax_ff, ax_in;
   logic [DW-1:0]         ay_ff, ay_in;
   logic signed [AW-1:0]  lhs_ff, lhs_in;
   logic signed [AW-1:0]  rhs_ff, rhs_in;
   coord_type             pos_x_ff, pos_x_in;
   coord_type             pos_y_ff, pos_y_in;
   logic                  gx_ff, gx_in;
   logic                  gy_ff, gy_in;

   logic signed [AW-1:0]  two_ax;
   logic signed [AW-1:0]  two_ay;
   logic signed [AW-1:0]  probe;
   logic                  in_last_col;
   logic                  at_end;
   logic                  stay;

   assign two_ax = $signed(AW'({ax_ff, 1'b0}));
   assign two_ay = $signed(AW'({ay_ff, 1'b0}));

   // lhs holds ax*(2*row-1), rhs holds ay*(2*col+1): the square one row up is
   // still touched while ax*(2*row+1) does not exceed rhs.
   assign probe       = lhs_ff + two_ax;
   assign in_last_col = (col_ff == ax_ff);
   assign at_end      = in_last_col && (row_ff == ay_ff);
   assign stay        = in_last_col ? (row_ff != ay_ff) : (probe <= rhs_ff);

   assign busy          = (state_ff == ST_WALK);
   assign square.valid  = (state_ff == ST_WALK);
   assign square.x      = pos_x_ff;
   assign square.y      = pos_y_ff;
   assign square.last   = at_end;

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      lhs_in   = lhs_ff;
      rhs_in   = rhs_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load.go) begin
               state_in = ST_WALK;
               col_in   = '0;
               row_in   = '0;
               ax_in    = load.ax[DW-1:0];
               ay_in    = load.ay[DW-1:0];
               lhs_in   = -$signed(AW'(load.ax[DW-1:0]));
               rhs_in   = $signed(AW'(load.ay[DW-1:0]));
               pos_x_in = load.sx;
               pos_y_in = load.sy;
               gx_in    = load.gx;
               gy_in    = load.gy;
            end
         end
         ST_WALK: begin
            if (at_end) begin
               state_in = ST_IDLE;
            end else if (stay) begin
               row_in   = row_ff + DW'(1);
               lhs_in   = probe;
               pos_y_in = gy_ff ? pos_y_ff + coord_type'(1) : pos_y_ff - coord_type'(1);
            end else begin
               col_in   = col_ff + DW'(1);
               rhs_in   = rhs_ff + two_ay;
               pos_x_in = gx_ff ? pos_x_ff + coord_type'(1) : pos_x_ff - coord_type'(1);
               // A crossing exactly at the corner also touches the row below.
               if (lhs_ff == rhs_ff) begin
                  row_in   = row_ff - DW'(1);
                  lhs_in   = lhs_ff - two_ax;
                  pos_y_in = gy_ff ? pos_y_ff - coord_type'(1) : pos_y_ff + coord_type'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      col_ff   <= col_in;
      row_ff   <= row_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      lhs_ff   <= lhs_in;
      rhs_ff   <= rhs_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
   end

endmodule

// ===== tb/sv/grid_line_square_enumerator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_line_square_enumerator_core: a table of
// directed moves and then random moves, every square checked against a typed
// row or a walk predictor held here. Depends on glse_pkg and the core itself.
module grid_line_square_enumerator_core_tb;
   import glse_pkg::*;

   localparam int MAX_DELTA    = 15;
   localparam int MAX_SQUARES  = 3 * MAX_DELTA + 1;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_TIME  = 10;
   localparam int PHASE_MOVES  = 119;

   // Fifth table column: where the expected squares come from.
   localparam int PREDICTED = 0;
   localparam int TYPED     = 1;

   localparam int DIRECTED_ROWS = 24;

   // start_x, start_y, end_x, end_y, source, square_x, square_y, too_far.
   // Typed rows expect a single square flagged as the last one.
   int directed_moves [DIRECTED_ROWS][8] = '{
      '{   0,    0,    0,    0, TYPED,        0,    0, 0},
      '{-128,  127, -128,  127, TYPED,     -128,  127, 0},
      '{ 127, -128,  127, -128, TYPED,      127, -128, 0},
      '{   0,    0,   16,    0, TYPED,        0,    0, 1},
      '{   0,    0,    0,  -16, TYPED,        0,    0, 1},
      '{-128, -128,  127,  127, TYPED,     -128, -128, 1},
      '{ 127,  127, -128, -128, TYPED,      127,  127, 1},
      '{  -5,    3,   11,    4, TYPED,       -5,    3, 1},
      '{  20,   20,   21,   -7, TYPED,       20,   20, 1},
      '{   0,    0,   15,    0, PREDICTED,    0,    0, 0},
      '{  10,    5,   -5,    5, PREDICTED,    0,    0, 0},
      '{   3,   -7,    3,    8, PREDICTED,    0,    0, 0},
      '{   3,    8,    3,   -7, PREDICTED,    0,    0, 0},
      '{   0,    0,   15,   15, PREDICTED,    0,    0, 0},
      '{   0,    0,  -15,  -15, PREDICTED,    0,    0, 0},
      '{   0,    0,   15,  -15, PREDICTED,    0,    0, 0},
      '{   0,    0,  -15,   15, PREDICTED,    0,    0, 0},
      '{   0,    0,   15,    1, PREDICTED,    0,    0, 0},
      '{   0,    0,    1,   15, PREDICTED,    0,    0, 0},
      '{   2,    2,    4,    3, PREDICTED,    0,    0, 0},
      '{   0,    0,   -3,    1, PREDICTED,    0,    0, 0},
      '{ 127,  127,  112,  112, PREDICTED,    0,    0, 0},
      '{-128, -128, -113, -113, PREDICTED,    0,    0, 0},
      '{ 100,  -50,  115,  -48, PREDICTED,    0,    0, 0}
   };

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_strobe;
   rsp_type rsp;

   rsp_type expected_squares [$];
   int      mismatches;
   int      squares_checked;
   int      moves_sent;
   int      rejected_moves;
   int      longest_walk;
   int      stall_cycles;
   int      sender_idle_pct;

   grid_line_square_enumerator_core #(
      .MAX_DELTA (MAX_DELTA)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void add_square(input int x, input int y, input bit far,
                                      inout int count);
      rsp_type sq;
      if (count < MAX_SQUARES) begin
         sq.square_x    = coord_type'(x);
         sq.square_y    = coord_type'(y);
         sq.last_square = 1'b0;
         sq.too_far     = far;
         expected_squares.push_back(sq);
         count++;
      end
   endfunction

   // Supercover walk in the frame where the move points right and up, with
   // columns in doubled x so that every border crossing is an integer test.
   function automatic void predict_squares(input req_type mv);
      int sx, sy, dx, dy, gx, gy, ax, ay;
      int x, y, col, num, count;
      sx = mv.start_x;
      sy = mv.start_y;
      dx = int'(mv.end_x) - sx;
      dy = int'(mv.end_y) - sy;
      gx = (dx > 0) ? 1 : -1;
      gy = (dy > 0) ? 1 : -1;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      count = 0;
      if (ax > MAX_DELTA || ay > MAX_DELTA) begin
         add_square(sx, sy, 1'b1, count);
         rejected_moves++;
      end else if (ax == 0) begin
         for (y = 0; y <= ay; y++) add_square(sx, sy + y * gy, 1'b0, count);
      end else if (ay == 0) begin
         for (x = 0; x <= ax; x++) add_square(sx + x * gx, sy, 1'b0, count);
      end else begin
         for (y = 0; ax * (2 * y - 1) <= ay; y++)
            add_square(sx, sy + y * gy, 1'b0, count);
         for (x = 1; x < 2 * ax - 1; x += 2) begin
            col = (x + 1) / 2;
            num = ay * x + ax;
            // An exact crossing on the left border also touches the row below.
            y = num / (2 * ax);
            if (num % (2 * ax) == 0) y--;
            for (; ax * (2 * y - 1) <= ay * (x + 2); y++)
               add_square(sx + col * gx, sy + y * gy, 1'b0, count);
         end
         num = ay * (2 * ax - 1) + ax;
         y = num / (2 * ax);
         if (num % (2 * ax) == 0) y--;
         for (; y <= ay; y++) add_square(sx + ax * gx, sy + y * gy, 1'b0, count);
      end
      if (count > 0) expected_squares[expected_squares.size() - 1].last_square = 1'b1;
      if (count > longest_walk) longest_walk = count;
   endfunction

   function automatic int keep_on_grid(input int from, input int delta);
      int target;
      target = from + delta;
      if (target > 127 || target < -128) target = from - delta;
      return target;
   endfunction

   function automatic req_type random_move();
      int sx, sy, ex, ey, pick;
      req_type mv;
      pick = $urandom_range(99);
      sx = int'($urandom_range(255)) - 128;
      sy = int'($urandom_range(255)) - 128;
      if (pick < 72) begin
         ex = keep_on_grid(sx, int'($urandom_range(30)) - 15);
         ey = keep_on_grid(sy, int'($urandom_range(30)) - 15);
      end else if (pick < 86) begin
         ex = sx;
         ey = sy;
         if ($urandom_range(1)) ex = keep_on_grid(sx, int'($urandom_range(30)) - 15);
         else ey = keep_on_grid(sy, int'($urandom_range(30)) - 15);
      end else if (pick < 93) begin
         // Just past the reach limit on one axis.
         ex = keep_on_grid(sx, int'($urandom_range(16, 20)) * ($urandom_range(1) ? 1 : -1));
         ey = keep_on_grid(sy, int'($urandom_range(30)) - 15);
         if ($urandom_range(1)) begin
            ey = ex - sx + sy;
            ey = keep_on_grid(sy, ex - sx);
            ex = keep_on_grid(sx, int'($urandom_range(30)) - 15);
         end
      end else begin
         ex = int'($urandom_range(255)) - 128;
         ey = int'($urandom_range(255)) - 128;
      end
      mv.start_x = coord_type'(sx);
      mv.start_y = coord_type'(sy);
      mv.end_x   = coord_type'(ex);
      mv.end_y   = coord_type'(ey);
      return mv;
   endfunction

   // Called at a rising edge; returns at the edge where the request is taken.
   task automatic send_move(input req_type mv);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req   <= mv;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      moves_sent++;
   endtask

   task automatic drain_squares();
      start <= 1'b0;
      @(posedge clock);
      while (expected_squares.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no request or square for %0d cycles, %0d squares pending",
                  STALL_LIMIT, expected_squares.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_squares.size() == 0) begin
            if (mismatches < 10)
               $display("Unexpected square x=%0d y=%0d last=%b far=%b",
                        rsp.square_x, rsp.square_y, rsp.last_square, rsp.too_far);
            mismatches++;
         end else begin
            want = expected_squares.pop_front();
            squares_checked++;
            if (rsp.square_x !== want.square_x || rsp.square_y !== want.square_y ||
                rsp.last_square !== want.last_square || rsp.too_far !== want.too_far) begin
               if (mismatches < 10)
                  $display({"Square mismatch: expected x=%0d y=%0d last=%b far=%b, ",
                            "got x=%0d y=%0d last=%b far=%b"},
                           want.square_x, want.square_y, want.last_square, want.too_far,
                           rsp.square_x, rsp.square_y, rsp.last_square, rsp.too_far);
               mismatches++;
            end
         end
      end
   end

   initial begin
      req_type mv;
      rsp_type typed_square;
      int      row;
      int      phase;
      int      n;
      mismatches      = 0;
      squares_checked = 0;
      moves_sent      = 0;
      rejected_moves  = 0;
      longest_walk    = 0;
      stall_cycles    = 0;
      sender_idle_pct = 9;
      reset <= 1'b1;
      start <= 1'b0;
      req   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         mv.start_x = coord_type'(directed_moves[row][0]);
         mv.start_y = coord_type'(directed_moves[row][1]);
         mv.end_x   = coord_type'(directed_moves[row][2]);
         mv.end_y   = coord_type'(directed_moves[row][3]);
         send_move(mv);
         if (directed_moves[row][4] == TYPED) begin
            typed_square.square_x    = coord_type'(directed_moves[row][5]);
            typed_square.square_y    = coord_type'(directed_moves[row][6]);
            typed_square.last_square = 1'b1;
            typed_square.too_far     = directed_moves[row][7][0];
            expected_squares.push_back(typed_square);
            if (typed_square.too_far) rejected_moves++;
         end else begin
            predict_squares(mv);
         end
      end
      // Hold the request side back until every square of the table is out.
      drain_squares();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: sender_idle_pct = 9;
            1: sender_idle_pct = 45;
            default: sender_idle_pct = 0;
         endcase
         for (n = 0; n < PHASE_MOVES; n++) begin
            mv = random_move();
            send_move(mv);
            predict_squares(mv);
         end
         drain_squares();
      end

      repeat (SETTLE_TIME) @(posedge clock);
      $display("Ran %0d moves (%0d rejected as too long) and checked %0d squares;",
               moves_sent, rejected_moves, squares_checked);
      $display("longest walk was %0d squares, sender idling at 9%%, 45%% and none.",
               longest_walk);
      if (mismatches == 0 && expected_squares.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d squares never arrived",
                  mismatches, expected_squares.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
